// ===== sv/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

	// Parser phase. The values follow the header byte order; MASK0..MASK3 take the key bytes.
	typedef enum logic [3:0] {
		PH_HDR0    = 4'd0,
		PH_HDR1    = 4'd1,
		PH_EXT_HI  = 4'd2,
		PH_EXT_LO  = 4'd3,
		PH_MASK0   = 4'd4,
		PH_MASK1   = 4'd5,
		PH_MASK2   = 4'd6,
		PH_MASK3   = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_DISCARD = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_PAYLOAD_TRUNC = 2'd1,
		ST_HEADER_TRUNC  = 2'd2,
		ST_LEN64         = 2'd3
	} status_t;

	localparam logic [3:0] OP_NONE  = 4'h0;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// One result as the front end classifies it; the back end applies the mask.
	typedef struct packed {
		logic [7:0]  raw_byte;
		logic [7:0]  key_byte;
		logic        masked;
		logic        byte_valid;
		logic        last;
		logic [3:0]  frame_opcode;
		logic [15:0] payload_length;
		status_t     status;
		logic [3:0]  reply_opcode;
	} wsd_cmd_t;

	function automatic logic [3:0] reply_for(input logic [3:0] opcode);
		logic [3:0] r;
		r = OP_NONE;
		if (opcode == OP_CLOSE) begin
			r = OP_CLOSE;
		end else if (opcode == OP_PING) begin
			r = OP_PONG;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/wsd_in_if.sv =====
// Input byte channel of the WebSocket frame deframer.
`default_nettype none
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       buffer_end;

	modport source(output valid, output in_byte, output buffer_end, input ready);
	modport sink(input valid, input in_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

// ===== sv/wsd_out_if.sv =====
// Result channel of the WebSocket frame deframer.
`default_nettype none
interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        last;
	logic [3:0]  frame_opcode;
	logic [15:0] payload_length;
	logic [1:0]  status;
	logic [3:0]  reply_opcode;

	modport source(output valid, output data_byte, output byte_valid, output last,
		output frame_opcode, output payload_length, output status, output reply_opcode,
		input ready);
	modport sink(input valid, input data_byte, input byte_valid, input last,
		input frame_opcode, input payload_length, input status, input reply_opcode,
		output ready);
endinterface
`default_nettype wire

// ===== sv/wsd_front.sv =====
// Front end: header parser that turns each accepted byte into zero or one result command.
`default_nettype none
module wsd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	wsd_in_if.sink            frame_in,
	input  wire logic         queue_full,
	output logic              push,
	output wsd_pkg::wsd_cmd_t cmd
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  key_q [4];

	logic        accept;
	logic        emit;
	logic [7:0]  b;
	logic        at_end;
	logic [6:0]  len7;
	logic [15:0] count_new;
	logic        fin;
	logic        hdr_complete;
	phase_t      done_phase;

	assign frame_in.ready = !queue_full;
	assign accept         = frame_in.valid && frame_in.ready;
	assign push           = accept && emit;
	assign b              = frame_in.in_byte;
	assign at_end         = frame_in.buffer_end;
	assign len7           = b[6:0];
	assign count_new      = count_q + 16'd1;
	assign fin            = (count_new >= len_q) || at_end;

	assign hdr_complete = ((phase_q == PH_HDR1) && (len7 < LEN_CODE_EXT16) && !b[7]) ||
		((phase_q == PH_EXT_LO) && !masked_q) || (phase_q == PH_MASK3);

	// Where the parser goes once the header is complete.
	assign done_phase = at_end ? PH_HDR0 : ((len_d == 16'd0) ? PH_DISCARD : PH_PAYLOAD);

	// Next values of the header fields.
	always_comb begin
		opcode_d = opcode_q;
		masked_d = masked_q;
		len_d    = len_q;
		count_d  = count_q;
		unique case (phase_q)
			PH_HDR1: begin
				masked_d = b[7];
				len_d    = (len7 >= LEN_CODE_EXT16) ? 16'd0 : {9'd0, len7};
			end
			PH_EXT_HI: len_d = {b, 8'd0};
			PH_EXT_LO: len_d = len_q | {8'd0, b};
			PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: ;
			PH_PAYLOAD: count_d = count_new;
			PH_DISCARD: ;
			default: begin
				opcode_d = b[3:0];
				masked_d = 1'b0;
				len_d    = 16'd0;
				count_d  = 16'd0;
			end
		endcase
	end

	// Next phase.
	always_comb begin
		unique case (phase_q)
			PH_HDR1: begin
				if (len7 == LEN_CODE_EXT64) begin
					phase_d = at_end ? PH_HDR0 : PH_DISCARD;
				end else if (len7 == LEN_CODE_EXT16) begin
					phase_d = at_end ? PH_HDR0 : PH_EXT_HI;
				end else if (b[7]) begin
					phase_d = at_end ? PH_HDR0 : PH_MASK0;
				end else begin
					phase_d = done_phase;
				end
			end
			PH_EXT_HI: phase_d = at_end ? PH_HDR0 : PH_EXT_LO;
			PH_EXT_LO: begin
				if (masked_q) begin
					phase_d = at_end ? PH_HDR0 : PH_MASK0;
				end else begin
					phase_d = done_phase;
				end
			end
			PH_MASK0: phase_d = at_end ? PH_HDR0 : PH_MASK1;
			PH_MASK1: phase_d = at_end ? PH_HDR0 : PH_MASK2;
			PH_MASK2: phase_d = at_end ? PH_HDR0 : PH_MASK3;
			PH_MASK3: phase_d = done_phase;
			PH_PAYLOAD: begin
				if (fin) begin
					phase_d = at_end ? PH_HDR0 : PH_DISCARD;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_DISCARD: phase_d = at_end ? PH_HDR0 : PH_DISCARD;
			default: phase_d = at_end ? PH_HDR0 : PH_HDR1;
		endcase
	end

	// Result command for the current byte.
	always_comb begin
		emit               = 1'b0;
		cmd.raw_byte       = 8'd0;
		cmd.key_byte       = 8'd0;
		cmd.masked         = 1'b0;
		cmd.byte_valid     = 1'b0;
		cmd.last           = 1'b1;
		cmd.frame_opcode   = opcode_d;
		cmd.payload_length = len_d;
		cmd.status         = ST_HEADER_TRUNC;
		cmd.reply_opcode   = OP_NONE;
		unique case (phase_q)
			PH_HDR1, PH_EXT_HI, PH_EXT_LO, PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
				if ((phase_q == PH_HDR1) && (len7 == LEN_CODE_EXT64)) begin
					emit       = 1'b1;
					cmd.status = ST_LEN64;
				end else if (hdr_complete) begin
					emit             = (len_d == 16'd0) || at_end;
					cmd.status       = (len_d == 16'd0) ? ST_OK : ST_PAYLOAD_TRUNC;
					cmd.reply_opcode = reply_for(opcode_d);
				end else begin
					emit = at_end;
				end
			end
			PH_PAYLOAD: begin
				emit           = 1'b1;
				cmd.raw_byte   = b;
				cmd.key_byte   = key_q[count_q[1:0]];
				cmd.masked     = masked_q;
				cmd.byte_valid = 1'b1;
				cmd.last       = fin;
				cmd.status     = (fin && (count_new < len_q)) ? ST_PAYLOAD_TRUNC : ST_OK;
				cmd.reply_opcode = fin ? reply_for(opcode_q) : OP_NONE;
			end
			PH_DISCARD: emit = 1'b0;
			default: emit = at_end;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			len_q    <= 16'd0;
			count_q  <= 16'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			count_q  <= count_d;
		end
	end

	// The key is read only after all four bytes of it have been written.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_MASK0: key_q[0] <= b;
				PH_MASK1: key_q[1] <= b;
				PH_MASK2: key_q[2] <= b;
				PH_MASK3: key_q[3] <= b;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/wsd_queue.sv =====
// Short command queue between the parser and the unmask stage.
`default_nettype none
module wsd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wsd_pkg::wsd_cmd_t push_cmd,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output wsd_pkg::wsd_cmd_t      head_cmd
);
	import wsd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	wsd_cmd_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== sv/wsd_back.sv =====
// Back end: applies the mask key and holds the result in the output register.
`default_nettype none
module wsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              not_empty,
	input  wire wsd_pkg::wsd_cmd_t head_cmd,
	output logic                   pop,
	wsd_out_if.source              result_out
);
	import wsd_pkg::*;

	logic        valid_q;
	logic [7:0]  data_q;
	logic        byte_valid_q;
	logic        last_q;
	logic [3:0]  opcode_q;
	logic [15:0] length_q;
	logic [1:0]  status_q;
	logic [3:0]  reply_q;

	assign pop = not_empty && (!valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q       <= (head_cmd.masked && head_cmd.byte_valid) ?
				(head_cmd.raw_byte ^ head_cmd.key_byte) : head_cmd.raw_byte;
			byte_valid_q <= head_cmd.byte_valid;
			last_q       <= head_cmd.last;
			opcode_q     <= head_cmd.frame_opcode;
			length_q     <= head_cmd.payload_length;
			status_q     <= head_cmd.status;
			reply_q      <= head_cmd.reply_opcode;
		end
	end

	assign result_out.valid          = valid_q;
	assign result_out.data_byte      = data_q;
	assign result_out.byte_valid     = byte_valid_q;
	assign result_out.last           = last_q;
	assign result_out.frame_opcode   = opcode_q;
	assign result_out.payload_length = length_q;
	assign result_out.status         = status_q;
	assign result_out.reply_opcode   = reply_q;

endmodule
`default_nettype wire

// ===== sv/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser, command queue and unmask stage.
//
// The block takes one received byte per transaction on frame_in, with buffer_end marking
// the last byte of a buffer, and sustains one byte per clock cycle in both directions
// while results are taken. The parser reads the header (opcode, mask bit, 7-bit length,
// optional 16-bit extended length, four mask key bytes) and, for each payload byte, hands
// a command to a short queue; the back stage unmasks the byte with the key and presents it
// on result_out through its output register. The parser keeps accepting bytes while a
// result waits to be taken until the QUEUE_DEPTH entry queue fills. Header bytes give no
// result unless the header completes with an empty payload, holds the 64-bit length code
// or the buffer ends inside it. The last result of a frame carries the status (ok, payload
// truncated, header truncated, 64-bit length unsupported) and the reply opcode: close for a
// close frame and pong for a ping frame. Bytes after a finished frame are dropped until
// buffer_end, after which the next byte starts a new frame.
`default_nettype none
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wsd_in_if.sink    frame_in,
	wsd_out_if.source result_out
);
	import wsd_pkg::*;

	// Commands from the parser to the queue, and from the queue head to the back stage.
	wsd_cmd_t front_cmd;
	wsd_cmd_t head_cmd;
	logic     push;
	logic     pop;
	logic     queue_full;
	logic     queue_not_empty;

	// The parser stalls only when the queue is full.
	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head_cmd  (head_cmd)
	);

	// The back stage drains the queue whenever its output register is free or being taken.
	wsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (queue_not_empty),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result_out (result_out)
	);

	// A result that does not end the frame is always a payload byte.
	a_mid_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.last) |-> result_out.byte_valid)
		else $error("non-final result without a payload byte");

	// Only the final result of a frame carries a status or a reply.
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && ((result_out.status != ST_OK) ||
		(result_out.reply_opcode != OP_NONE))) |-> result_out.last)
		else $error("status or reply on a non-final result");

	// Header failures never come with a reply.
	a_no_reply_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && ((result_out.status == ST_HEADER_TRUNC) ||
		(result_out.status == ST_LEN64))) |-> (result_out.reply_opcode == OP_NONE))
		else $error("reply given on a failed header");

	// The unsupported length code reports no length.
	a_len64_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && (result_out.status == ST_LEN64)) |->
		(result_out.payload_length == 16'd0 && !result_out.byte_valid))
		else $error("64-bit length result with length or data");

endmodule
`default_nettype wire
